// ----- design/m6502_pkg.sv -----
// Shared types, opcode tables and a helper function for the 6502 instruction splitter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package m6502_pkg;

  localparam int ADDR_W = 17;

  localparam logic [15:0] START_RESET = 16'h8000;
  localparam logic [23:0] QMARKS      = 24'h3F3F3F;

  // register indexes, taken from paddr[2]
  localparam logic [0:0] REG_START   = 1'b0;
  localparam logic [0:0] REG_ILLEGAL = 1'b1;

  typedef enum logic [3:0] {
    AM_IMP = 4'd0,
    AM_ACC = 4'd1,
    AM_IMM = 4'd2,
    AM_ADR = 4'd3,
    AM_ABS = 4'd4,
    AM_IND = 4'd5,
    AM_REL = 4'd6,
    AM_ABX = 4'd7,
    AM_ABY = 4'd8,
    AM_ZPG = 4'd9,
    AM_ZPX = 4'd10,
    AM_ZPY = 4'd11,
    AM_INX = 4'd12,
    AM_INY = 4'd13,
    AM_ERR = 4'd14
  } addr_mode_t;

  typedef struct packed {
    addr_mode_t  mode;
    logic [23:0] chars;
    logic        undoc;
  } dec_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode_byte;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    addr_mode_t  addr_mode;
    logic [1:0]  instr_length;
    logic [15:0] operand_value;
    logic [23:0] mnemonic_chars;
    logic        undocumented;
    logic        truncated;
  } rec_t;

  localparam addr_mode_t MODE_TAB [256] = '{
    AM_IMM, AM_INX, AM_ERR, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_ACC, AM_IMM, AM_ABS, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABX, AM_ABX,
    AM_ADR, AM_INX, AM_ERR, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_ACC, AM_IMM, AM_ABS, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABX, AM_ABX,
    AM_IMP, AM_INX, AM_ERR, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_ACC, AM_IMM, AM_ADR, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABX, AM_ABX,
    AM_IMP, AM_INX, AM_ERR, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_ACC, AM_IMM, AM_IND, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABX, AM_ABX,
    AM_IMM, AM_INX, AM_IMM, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_IMP, AM_IMM, AM_ABS, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPY, AM_ZPY,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABY, AM_ABY,
    AM_IMM, AM_INX, AM_IMM, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_IMP, AM_IMM, AM_ABS, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPY, AM_ZPY,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABY, AM_ABY,
    AM_IMM, AM_INX, AM_IMM, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_IMP, AM_IMM, AM_ABS, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABX, AM_ABX,
    AM_IMM, AM_INX, AM_IMM, AM_INX, AM_ZPG, AM_ZPG, AM_ZPG, AM_ZPG,
    AM_IMP, AM_IMM, AM_IMP, AM_IMM, AM_ABS, AM_ABS, AM_ABS, AM_ABS,
    AM_REL, AM_INY, AM_ERR, AM_INY, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX,
    AM_IMP, AM_ABY, AM_IMP, AM_ABY, AM_ABX, AM_ABX, AM_ABX, AM_ABX
  };

  // {undocumented, three ASCII letters}
  localparam logic U = 1'b1;
  localparam logic D = 1'b0;

  localparam logic [24:0] NAME_TAB [256] = '{
    {D,"BRK"}, {D,"ORA"}, {U,"HLT"}, {U,"SLO"}, {U,"NOP"}, {D,"ORA"}, {D,"ASL"}, {U,"SLO"},
    {D,"PHP"}, {D,"ORA"}, {D,"ASL"}, {D,"???"}, {U,"NOP"}, {D,"ORA"}, {D,"ASL"}, {U,"SLO"},
    {D,"BPL"}, {D,"ORA"}, {U,"HLT"}, {U,"SLO"}, {U,"NOP"}, {D,"ORA"}, {D,"ASL"}, {U,"SLO"},
    {D,"CLC"}, {D,"ORA"}, {U,"NOP"}, {U,"SLO"}, {U,"NOP"}, {D,"ORA"}, {D,"ASL"}, {U,"SLO"},
    {D,"JSR"}, {D,"AND"}, {U,"HLT"}, {U,"RLA"}, {D,"BIT"}, {D,"AND"}, {D,"ROL"}, {U,"RLA"},
    {D,"PLP"}, {D,"AND"}, {D,"ROL"}, {D,"???"}, {D,"BIT"}, {D,"AND"}, {D,"ROL"}, {U,"RLA"},
    {D,"BMI"}, {D,"AND"}, {U,"HLT"}, {U,"RLA"}, {U,"NOP"}, {D,"AND"}, {D,"ROL"}, {U,"RLA"},
    {D,"SEC"}, {D,"AND"}, {U,"NOP"}, {U,"RLA"}, {U,"NOP"}, {D,"AND"}, {D,"ROL"}, {U,"RLA"},
    {D,"RTI"}, {D,"EOR"}, {U,"HLT"}, {U,"SRE"}, {U,"NOP"}, {D,"EOR"}, {D,"LSR"}, {U,"SRE"},
    {D,"PHA"}, {D,"EOR"}, {D,"LSR"}, {D,"???"}, {D,"JMP"}, {D,"EOR"}, {D,"LSR"}, {U,"SRE"},
    {D,"BVC"}, {D,"EOR"}, {U,"HLT"}, {U,"SRE"}, {U,"NOP"}, {D,"EOR"}, {D,"LSR"}, {U,"SRE"},
    {D,"CLI"}, {D,"EOR"}, {U,"NOP"}, {U,"SRE"}, {U,"NOP"}, {D,"EOR"}, {D,"LSR"}, {U,"SRE"},
    {D,"RTS"}, {D,"ADC"}, {U,"HLT"}, {U,"RRA"}, {U,"NOP"}, {D,"ADC"}, {D,"ROR"}, {U,"RRA"},
    {D,"PLA"}, {D,"ADC"}, {D,"ROR"}, {D,"???"}, {D,"JMP"}, {D,"ADC"}, {D,"ROR"}, {U,"RRA"},
    {D,"BVS"}, {D,"ADC"}, {U,"HLT"}, {U,"RRA"}, {U,"NOP"}, {D,"ADC"}, {D,"ROR"}, {U,"RRA"},
    {D,"SEI"}, {D,"ADC"}, {U,"NOP"}, {U,"RRA"}, {U,"NOP"}, {D,"ADC"}, {D,"ROR"}, {U,"RRA"},
    {U,"NOP"}, {D,"STA"}, {U,"NOP"}, {U,"SAX"}, {D,"STY"}, {D,"STA"}, {D,"STX"}, {U,"SAX"},
    {D,"DEY"}, {U,"NOP"}, {D,"TXA"}, {D,"???"}, {D,"STY"}, {D,"STA"}, {D,"STX"}, {U,"SAX"},
    {D,"BCC"}, {D,"STA"}, {U,"HLT"}, {D,"???"}, {D,"STY"}, {D,"STA"}, {D,"STX"}, {U,"SAX"},
    {D,"TYA"}, {D,"STA"}, {D,"TXS"}, {D,"???"}, {D,"???"}, {D,"STA"}, {D,"???"}, {D,"???"},
    {D,"LDY"}, {D,"LDA"}, {D,"LDX"}, {U,"LAX"}, {D,"LDY"}, {D,"LDA"}, {D,"LDX"}, {U,"LAX"},
    {D,"TAY"}, {D,"LDA"}, {D,"TAX"}, {D,"???"}, {D,"LDY"}, {D,"LDA"}, {D,"LDX"}, {U,"LAX"},
    {D,"BCS"}, {D,"LDA"}, {U,"HLT"}, {U,"LAX"}, {D,"LDY"}, {D,"LDA"}, {D,"LDX"}, {U,"LAX"},
    {D,"CLV"}, {D,"LDA"}, {D,"TSX"}, {D,"???"}, {D,"LDY"}, {D,"LDA"}, {D,"LDX"}, {U,"LAX"},
    {D,"CPY"}, {D,"CMP"}, {U,"NOP"}, {U,"DCP"}, {D,"CPY"}, {D,"CMP"}, {D,"DEC"}, {U,"DCP"},
    {D,"INY"}, {D,"CMP"}, {D,"DEX"}, {D,"???"}, {D,"CPY"}, {D,"CMP"}, {D,"DEC"}, {U,"DCP"},
    {D,"BNE"}, {D,"CMP"}, {U,"HLT"}, {U,"DCP"}, {U,"NOP"}, {D,"CMP"}, {D,"DEC"}, {U,"DCP"},
    {D,"CLD"}, {D,"CMP"}, {U,"NOP"}, {U,"DCP"}, {U,"NOP"}, {D,"CMP"}, {D,"DEC"}, {U,"DCP"},
    {D,"CPX"}, {D,"SBC"}, {U,"NOP"}, {U,"ISB"}, {D,"CPX"}, {D,"SBC"}, {D,"INC"}, {U,"ISB"},
    {D,"INX"}, {D,"SBC"}, {D,"NOP"}, {U,"SBC"}, {D,"CPX"}, {D,"SBC"}, {D,"INC"}, {U,"ISB"},
    {D,"BEQ"}, {D,"SBC"}, {U,"HLT"}, {U,"ISB"}, {U,"NOP"}, {D,"SBC"}, {D,"INC"}, {U,"ISB"},
    {D,"SED"}, {D,"SBC"}, {U,"NOP"}, {U,"ISB"}, {U,"NOP"}, {D,"SBC"}, {D,"INC"}, {U,"ISB"}
  };

  function automatic logic [1:0] mode_len(addr_mode_t m);
    logic [1:0] len;
    unique case (m) inside
      AM_ADR, AM_ABS, AM_IND, AM_ABX, AM_ABY:                 len = 2'd3;
      AM_IMM, AM_REL, AM_ZPG, AM_ZPX, AM_ZPY, AM_INX, AM_INY: len = 2'd2;
      default:                                                len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- design/mos6502_instruction_splitter.sv -----
// Top level of the 6502 instruction splitter: APB register port, byte sequencer, output buffer.
// Depends on m6502_pkg, m6502_core (with m6502_decode) and m6502_outbuf.

// Takes one byte of a 6502 code image per clock while in_stall is low and returns one
// decoded record per instruction: address, raw bytes, addressing mode, length, operand or
// branch target, mnemonic letters and undocumented/truncated flags. The record is registered
// into the result register, or into the skid register while the result register holds a
// record that is not leaving, from the opcode table lookup and operand adder ahead of it.
// Results pass through a two-entry buffer (result register plus skid), so input keeps
// flowing while one record waits; in_stall rises only when both entries are occupied.
// Registers: start_address at 0x0, allow_illegal at 0x4; writing start_address restarts
// the image there. After the byte marked final, bytes are dropped until the next
// start_address write or reset.
module mos6502_instruction_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_instr_address,
  output logic [7:0]  out_opcode_byte,
  output logic [7:0]  out_operand_low,
  output logic [7:0]  out_operand_high,
  output logic [3:0]  out_addr_mode,
  output logic [1:0]  out_instr_length,
  output logic [15:0] out_operand_value,
  output logic [23:0] out_mnemonic_chars,
  output logic        out_undocumented,
  output logic        out_truncated
);

  logic            push;
  logic            full;
  m6502_pkg::rec_t rec;
  m6502_pkg::rec_t out_rec;

  assign pready   = 1'b1;
  assign in_stall = full;

  m6502_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_byte  (in_code_byte),
    .in_final_byte (in_final_byte),
    .push          (push),
    .rec           (rec)
  );

  m6502_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (rec),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  assign out_instr_address  = out_rec.instr_address;
  assign out_opcode_byte    = out_rec.opcode_byte;
  assign out_operand_low    = out_rec.operand_low;
  assign out_operand_high   = out_rec.operand_high;
  assign out_addr_mode      = out_rec.addr_mode;
  assign out_instr_length   = out_rec.instr_length;
  assign out_operand_value  = out_rec.operand_value;
  assign out_mnemonic_chars = out_rec.mnemonic_chars;
  assign out_undocumented   = out_rec.undocumented;
  assign out_truncated      = out_rec.truncated;

endmodule

// ----- design/m6502_decode.sv -----
// Opcode lookup: addressing mode, mnemonic letters and undocumented flag.
// Depends on m6502_pkg for the tables and the decode record type.
module m6502_decode (
  input  logic [7:0]      opcode,
  output m6502_pkg::dec_t dec
);

  logic [24:0] name_ent;

  assign name_ent  = m6502_pkg::NAME_TAB[opcode];
  assign dec.mode  = m6502_pkg::MODE_TAB[opcode];
  assign dec.chars = name_ent[23:0];
  assign dec.undoc = name_ent[24];

endmodule

// ----- design/m6502_core.sv -----
// Byte sequencer: configuration registers, instruction state and record assembly.
// Depends on m6502_pkg and m6502_decode.
module m6502_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              in_code_byte,
  input  logic                    in_final_byte,
  output logic                    push,
  output m6502_pkg::rec_t         rec
);

  logic [15:0]                     start_r, start_nxt;
  logic                            illegal_r, illegal_nxt;
  logic [m6502_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [1:0]                      pend_r, pend_nxt;
  logic [7:0]                      held_op_r, held_op_nxt;
  logic [7:0]                      held_lo_r, held_lo_nxt;
  logic                            halt_r, halt_nxt;

  logic                            accept;
  logic                            cfg_wr;
  logic [0:0]                      cfg_idx;
  logic [7:0]                      dec_op;
  m6502_pkg::dec_t                 dec;
  logic                            forced;
  m6502_pkg::addr_mode_t           new_mode;
  logic [1:0]                      new_len;
  logic [1:0]                      held_len;

  m6502_pkg::addr_mode_t           e_mode;
  logic [1:0]                      e_len;
  logic [7:0]                      e_lo, e_hi;
  logic                            e_forced, e_trunc;
  logic [15:0]                     e_val;

  assign accept  = in_valid && !in_stall;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2:2];

  // an opcode byte decodes itself, an operand byte decodes the held opcode
  assign dec_op = (pend_r == 2'd0) ? in_code_byte : held_op_r;

  m6502_decode u_decode (
    .opcode (dec_op),
    .dec    (dec)
  );

  assign forced   = !illegal_r && dec.undoc;
  assign new_mode = forced ? m6502_pkg::AM_ERR : dec.mode;
  assign new_len  = m6502_pkg::mode_len(new_mode);
  assign held_len = m6502_pkg::mode_len(dec.mode);
  assign e_len    = m6502_pkg::mode_len(e_mode);

  always_comb begin
    unique case (cfg_idx)
      m6502_pkg::REG_START:   prdata = {16'd0, start_r};
      m6502_pkg::REG_ILLEGAL: prdata = {31'd0, illegal_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_comb begin
    start_nxt   = start_r;
    illegal_nxt = illegal_r;
    addr_nxt    = addr_r;
    pend_nxt    = pend_r;
    held_op_nxt = held_op_r;
    held_lo_nxt = held_lo_r;
    halt_nxt    = halt_r;
    push        = 1'b0;
    e_mode      = dec.mode;
    e_lo        = 8'd0;
    e_hi        = 8'd0;
    e_forced    = 1'b0;
    e_trunc     = 1'b0;

    if (accept && !halt_r) begin
      case (pend_r)
        2'd0: begin
          // opcodes past the top of the address space are dropped
          if (!addr_r[m6502_pkg::ADDR_W-1]) begin
            e_mode = new_mode;
            if (new_len == 2'd1) begin
              push     = 1'b1;
              e_forced = forced;
            end else begin
              held_op_nxt = in_code_byte;
              held_lo_nxt = 8'd0;
              pend_nxt    = new_len - 2'd1;
              if (in_final_byte) begin
                push    = 1'b1;
                e_trunc = 1'b1;
              end
            end
          end
        end
        2'd2: begin
          held_lo_nxt = in_code_byte;
          pend_nxt    = 2'd1;
          if (in_final_byte) begin
            push    = 1'b1;
            e_lo    = in_code_byte;
            e_trunc = 1'b1;
          end
        end
        default: begin
          push = 1'b1;
          if (held_len == 2'd2) begin
            e_lo = in_code_byte;
          end else begin
            e_lo = held_lo_r;
            e_hi = in_code_byte;
          end
        end
      endcase
      if (push) begin
        addr_nxt = addr_r + {{(m6502_pkg::ADDR_W-2){1'b0}}, e_len};
        pend_nxt = 2'd0;
      end
      if (in_final_byte) begin
        halt_nxt = 1'b1;
      end
    end

    if (cfg_wr) begin
      unique case (cfg_idx)
        m6502_pkg::REG_START: begin
          start_nxt = pwdata[15:0];
          addr_nxt  = {1'b0, pwdata[15:0]};
          pend_nxt  = 2'd0;
          halt_nxt  = 1'b0;
        end
        m6502_pkg::REG_ILLEGAL: illegal_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (e_mode) inside
      m6502_pkg::AM_ADR, m6502_pkg::AM_ABS, m6502_pkg::AM_IND,
      m6502_pkg::AM_ABX, m6502_pkg::AM_ABY:
        e_val = {e_hi, e_lo};
      m6502_pkg::AM_IMM, m6502_pkg::AM_ZPG, m6502_pkg::AM_ZPX,
      m6502_pkg::AM_ZPY, m6502_pkg::AM_INX, m6502_pkg::AM_INY:
        e_val = {8'd0, e_lo};
      m6502_pkg::AM_REL:
        e_val = addr_r[15:0] + 16'd2 + {{8{e_lo[7]}}, e_lo};
      default:
        e_val = 16'd0;
    endcase
  end

  assign rec.instr_address  = addr_r[15:0];
  assign rec.opcode_byte    = dec_op;
  assign rec.operand_low    = e_lo;
  assign rec.operand_high   = e_hi;
  assign rec.addr_mode      = e_mode;
  assign rec.instr_length   = e_len;
  assign rec.operand_value  = e_val;
  assign rec.mnemonic_chars = e_forced ? m6502_pkg::QMARKS : dec.chars;
  assign rec.undocumented   = dec.undoc;
  assign rec.truncated      = e_trunc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= m6502_pkg::START_RESET;
      illegal_r <= 1'b0;
      addr_r    <= {1'b0, m6502_pkg::START_RESET};
      pend_r    <= 2'd0;
      held_op_r <= 8'd0;
      held_lo_r <= 8'd0;
      halt_r    <= 1'b0;
    end else begin
      start_r   <= start_nxt;
      illegal_r <= illegal_nxt;
      addr_r    <= addr_nxt;
      pend_r    <= pend_nxt;
      held_op_r <= held_op_nxt;
      held_lo_r <= held_lo_nxt;
      halt_r    <= halt_nxt;
    end
  end

`ifndef SYNTH
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && halt_r) |-> !push)
    else $error("record produced after end of image");

  a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (pend_r == 2'd0))
    else $error("operand bytes still pending after a record");

  a_trunc_final: assert property (@(posedge clk) disable iff (!rst_n)
    (push && rec.truncated) |-> in_final_byte)
    else $error("truncated record without final byte");
`endif

endmodule

// ----- design/m6502_outbuf.sv -----
// Two-entry output buffer: result register plus skid register.
// Depends on m6502_pkg for the record type.
module m6502_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  m6502_pkg::rec_t push_rec,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output m6502_pkg::rec_t out_rec
);

  logic            main_v_r, main_v_nxt;
  logic            skid_v_r, skid_v_nxt;
  m6502_pkg::rec_t main_r, main_nxt;
  m6502_pkg::rec_t skid_r, skid_nxt;
  logic            pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_rec   = main_r;

  // push never arrives with the skid register full: input is stalled then
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop && skid_v_r) begin
      main_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end else if (push && (!main_v_r || pop)) begin
      main_nxt   = push_rec;
      main_v_nxt = 1'b1;
    end else if (push) begin
      skid_nxt   = push_rec;
      skid_v_nxt = 1'b1;
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTH
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held with empty result register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(main_v_r && out_stall && push))
    else $error("skid register filled without a stalled transaction");
`endif

endmodule
